/* rtl/core/plte_pkg.sv */
// Shared types, constants and helpers for the piecewise-linear table engine.
package plte_pkg;

   localparam int MAX_POINTS = 64;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int POS_W      = 16;
   localparam int VAL_W      = 32;
   localparam int MEM_W      = POS_W + VAL_W;
   localparam int MUL_W      = 34;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int DIV_W      = 64;
   localparam int DVS_W      = 16;
   localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
   localparam int SUM_W      = 64;
   localparam int DQ_W       = DVS_W + 64;
   localparam int SQ_SHIFT   = 17;
   localparam int SQ_DIVISOR = 3;
   localparam int D3_CHUNK   = 16;
   localparam int D3_STEPS   = SUM_W / D3_CHUNK;
   localparam int D3_CNT_W   = $clog2(D3_STEPS);
   localparam int D3_CUR_W   = D3_CHUNK + 2;
   localparam int D3_SHIFT   = 20;
   localparam int D3_RECIP   = ((1 << D3_SHIFT) + SQ_DIVISOR - 1) / SQ_DIVISOR;
   localparam int D3_PROD_W  = D3_CUR_W + D3_SHIFT;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_EVAL   = 2'd1,
      FUNC_INTEG  = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_DUP   = 2'd3
   } status_type;

   function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [SUM_W-1:0] b);
      logic signed [SUM_W:0] s;
      begin
         s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
         if (s[SUM_W] != s[SUM_W-1]) begin
            sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
         end else begin
            sat_add = s[SUM_W-1:0];
         end
      end
   endfunction

endpackage

/* rtl/core/piecewise_linear_table_engine_unit.sv */
// Top level: point table, command sequencer, shared multiplier and a divider.
// Holds up to MAX_POINTS points sorted by position in a one-port-write,
// one-port-read table and runs one request at a time; req_stall is high
// from acceptance until the result is loaded into the output register.
// Per request: insert scans the stored entries for a duplicate and then moves
// each larger entry up; evaluate searches the segments and then runs the
// 64-step restoring divider; integrate runs, per segment, two squares, the
// cross product, the area product, two partial products and a four-step
// division by three of the scaled square-term product; clear only resets
// the point count. No table initialization is needed after reset.
module piecewise_linear_table_engine_unit
   import plte_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_func,
   input  logic [POS_W-1:0]        req_x,
   input  logic signed [VAL_W-1:0] req_y,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [VAL_W-1:0] rsp_value_out,
   output logic signed [SUM_W-1:0] rsp_area,
   output logic signed [SUM_W-1:0] rsp_area_of_square,
   output logic [1:0]              rsp_status
);

   typedef enum logic [4:0] {
      IDLE, INS_RD, INS_CHK, SH_RD, SH_CHK, SH_PUT,
      EV_A, EV_B, EV_C, EV_M0, EV_M1, EV_M2, EV_DIV, EV_WAIT,
      IN_A, IN_B, IN_C, S0, S1, S2, S3, S4, S5, S6, S_WAIT, IN_NEXT,
      DONE
   } state_type;

   state_type               state_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        idx_ff;
   logic [CNT_W-1:0]        p_ff;
   logic [POS_W-1:0]        x_ff;
   logic signed [VAL_W-1:0] y_ff;
   logic [POS_W-1:0]        x0_ff, x1_ff;
   logic signed [VAL_W-1:0] y0_ff, y1_ff;
   logic signed [PROD_W-1:0] acc_ff;
   logic signed [PROD_W-1:0] q_ff;
   logic [PROD_W-1:0]       ph_ff;
   logic signed [VAL_W-1:0] value_ff;
   logic signed [SUM_W-1:0] area_ff, sq_ff;
   status_type              status_ff;
   logic                    rsp_valid_ff;
   logic signed [VAL_W-1:0] rsp_value_ff;
   logic signed [SUM_W-1:0] rsp_area_ff, rsp_sq_ff;
   status_type              rsp_status_ff;

   logic [MEM_W-1:0]        mem [MAX_POINTS];
   logic [MEM_W-1:0]        mem_rd_ff;
   logic [ADDR_W-1:0]       mem_ra, mem_wa;
   logic [MEM_W-1:0]        mem_wd;
   logic                    mem_we;
   logic [POS_W-1:0]        rd_pos;
   logic signed [VAL_W-1:0] rd_val;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_prod;
   logic                     div_start, div_busy, div_done;
   logic [DIV_W-1:0]         div_dividend, div_quot;
   logic [DVS_W-1:0]         div_divisor;

   logic [POS_W-1:0]         seg_d;
   logic signed [VAL_W:0]    y_sum;
   logic signed [PROD_W-1:0] area_adj;
   logic signed [PROD_W-1:0] area_term;
   logic signed [PROD_W-1:0] acc_mag;
   logic [DQ_W-1:0]          dq;
   logic signed [DIV_W-1:0]  ev_q;

   logic [SUM_W-1:0]         d3_num_ff;
   logic [SUM_W-1:0]         d3_quo_ff;
   logic [1:0]               d3_rem_ff;
   logic [D3_CNT_W-1:0]      d3_cnt_ff;
   logic [D3_CUR_W-1:0]      d3_cur;
   logic [D3_PROD_W-1:0]     d3_prod;
   logic [D3_CHUNK-1:0]      d3_digit;
   logic [D3_CUR_W-1:0]      d3_back;
   logic [1:0]               d3_rem;

   assign rd_pos = mem_rd_ff[VAL_W +: POS_W];
   assign rd_val = mem_rd_ff[VAL_W-1:0];
   assign seg_d  = x1_ff - x0_ff;
   assign y_sum  = {y0_ff[VAL_W-1], y0_ff} + {y1_ff[VAL_W-1], y1_ff};

   // table: registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem[mem_ra];
   end

   always_comb begin
      case (state_ff)
         INS_RD:         mem_ra = idx_ff[ADDR_W-1:0];
         SH_RD:          mem_ra = ADDR_W'(p_ff - 1'b1);
         EV_B, IN_B:     mem_ra = ADDR_W'(1);
         EV_C, IN_NEXT:  mem_ra = ADDR_W'(idx_ff + 1'b1);
         default:        mem_ra = '0;
      endcase
   end

   assign mem_we = (state_ff == SH_PUT) || ((state_ff == SH_CHK) && (rd_pos > x_ff));
   assign mem_wa = p_ff[ADDR_W-1:0];
   assign mem_wd = (state_ff == SH_PUT) ? {x_ff, y_ff} : mem_rd_ff;

   always_comb begin
      case (state_ff)
         EV_M0: begin
            mul_a = MUL_W'(y0_ff);
            mul_b = MUL_W'({1'b0, seg_d});
         end
         EV_M1: begin
            mul_a = MUL_W'({1'b0, x_ff - x0_ff});
            mul_b = MUL_W'(y1_ff) - MUL_W'(y0_ff);
         end
         S0: begin
            mul_a = MUL_W'(y0_ff);
            mul_b = MUL_W'(y0_ff);
         end
         S1: begin
            mul_a = MUL_W'(y1_ff);
            mul_b = MUL_W'(y1_ff);
         end
         S2: begin
            mul_a = MUL_W'(y0_ff);
            mul_b = MUL_W'(y1_ff);
         end
         S3: begin
            mul_a = MUL_W'({1'b0, seg_d});
            mul_b = MUL_W'(y_sum);
         end
         S4: begin
            mul_a = MUL_W'({1'b0, seg_d});
            mul_b = MUL_W'({1'b0, q_ff[63:32]});
         end
         S5: begin
            mul_a = MUL_W'({1'b0, seg_d});
            mul_b = MUL_W'({1'b0, q_ff[31:0]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   plte_mul u_mul (
      .clock   (clock),
      .a_in    (mul_a),
      .b_in    (mul_b),
      .prod_ff (mul_prod)
   );

   // area term: d*(y0+y1)/4 rounded toward zero
   assign area_adj  = mul_prod[PROD_W-1] ? (mul_prod + PROD_W'(3)) : mul_prod;
   assign area_term = area_adj >>> 2;
   assign acc_mag   = acc_ff[PROD_W-1] ? -acc_ff : acc_ff;
   assign dq        = {ph_ff[DQ_W-33:0], 32'b0} + DQ_W'($unsigned(mul_prod));

   assign div_start    = (state_ff == EV_DIV);
   assign div_dividend = DIV_W'($unsigned(acc_mag));
   assign div_divisor  = seg_d;

   plte_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quot     (div_quot)
   );

   assign ev_q = acc_ff[PROD_W-1] ? -$signed(div_quot) : $signed(div_quot);

   // divide by three, 16 bits per step; the reciprocal is exact while the
   // partial dividend stays below 2^19
   assign d3_cur   = {d3_rem_ff, d3_num_ff[SUM_W-1 -: D3_CHUNK]};
   assign d3_prod  = D3_PROD_W'(d3_cur) * D3_PROD_W'(D3_RECIP);
   assign d3_digit = d3_prod[D3_SHIFT +: D3_CHUNK];
   assign d3_back  = D3_CUR_W'(d3_digit) * D3_CUR_W'(SQ_DIVISOR);
   assign d3_rem   = 2'(d3_cur - d3_back);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  x_ff      <= req_x;
                  y_ff      <= req_y;
                  value_ff  <= '0;
                  area_ff   <= '0;
                  sq_ff     <= '0;
                  idx_ff    <= '0;
                  case (func_type'(req_func))
                     FUNC_INSERT: begin
                        status_ff <= ST_OK;
                        p_ff      <= '0;
                        state_ff  <= (count_ff == '0) ? SH_RD : INS_RD;
                     end
                     FUNC_EVAL: begin
                        status_ff <= ST_RANGE;
                        state_ff  <= (count_ff < CNT_W'(2)) ? DONE : EV_A;
                     end
                     FUNC_INTEG: begin
                        status_ff <= ST_OK;
                        state_ff  <= (count_ff < CNT_W'(2)) ? DONE : IN_A;
                     end
                     default: begin
                        status_ff <= ST_OK;
                        count_ff  <= '0;
                        state_ff  <= DONE;
                     end
                  endcase
               end
            end
            INS_RD: state_ff <= INS_CHK;
            INS_CHK: begin
               if (rd_pos == x_ff) begin
                  status_ff <= ST_DUP;
                  state_ff  <= DONE;
               end else if (idx_ff + 1'b1 < count_ff) begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= INS_RD;
               end else if (count_ff == CNT_W'(MAX_POINTS)) begin
                  status_ff <= ST_FULL;
                  state_ff  <= DONE;
               end else begin
                  p_ff     <= count_ff;
                  state_ff <= SH_RD;
               end
            end
            SH_RD: state_ff <= (p_ff == '0) ? SH_PUT : SH_CHK;
            SH_CHK: begin
               if (rd_pos > x_ff) begin
                  p_ff     <= p_ff - 1'b1;
                  state_ff <= SH_RD;
               end else begin
                  state_ff <= SH_PUT;
               end
            end
            SH_PUT: begin
               count_ff <= count_ff + 1'b1;
               state_ff <= DONE;
            end
            EV_A: state_ff <= EV_B;
            EV_B: begin
               x0_ff    <= rd_pos;
               y0_ff    <= rd_val;
               idx_ff   <= CNT_W'(1);
               state_ff <= EV_C;
            end
            EV_C: begin
               if ((x0_ff <= x_ff) && (x_ff <= rd_pos)) begin
                  x1_ff    <= rd_pos;
                  y1_ff    <= rd_val;
                  state_ff <= EV_M0;
               end else if (idx_ff + 1'b1 < count_ff) begin
                  x0_ff  <= rd_pos;
                  y0_ff  <= rd_val;
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  state_ff <= DONE;
               end
            end
            EV_M0: state_ff <= EV_M1;
            EV_M1: begin
               acc_ff   <= mul_prod;
               state_ff <= EV_M2;
            end
            EV_M2: begin
               acc_ff   <= acc_ff + mul_prod;
               state_ff <= EV_DIV;
            end
            EV_DIV: state_ff <= EV_WAIT;
            EV_WAIT: begin
               if (div_done) begin
                  value_ff  <= ev_q[VAL_W-1:0];
                  status_ff <= ST_OK;
                  state_ff  <= DONE;
               end
            end
            IN_A: state_ff <= IN_B;
            IN_B: begin
               x0_ff    <= rd_pos;
               y0_ff    <= rd_val;
               idx_ff   <= CNT_W'(1);
               state_ff <= IN_C;
            end
            IN_C: begin
               x1_ff    <= rd_pos;
               y1_ff    <= rd_val;
               state_ff <= S0;
            end
            S0: state_ff <= S1;
            S1: begin
               q_ff     <= mul_prod;
               state_ff <= S2;
            end
            S2: begin
               q_ff     <= q_ff + mul_prod;
               state_ff <= S3;
            end
            S3: begin
               q_ff     <= q_ff + mul_prod;
               state_ff <= S4;
            end
            S4: begin
               area_ff  <= sat_add(area_ff, area_term[SUM_W-1:0]);
               state_ff <= S5;
            end
            S5: begin
               ph_ff    <= $unsigned(mul_prod);
               state_ff <= S6;
            end
            S6: begin
               d3_num_ff <= {1'b0, dq[DQ_W-1:SQ_SHIFT]};
               d3_rem_ff <= '0;
               d3_cnt_ff <= '0;
               state_ff  <= S_WAIT;
            end
            S_WAIT: begin
               d3_num_ff <= d3_num_ff << D3_CHUNK;
               d3_rem_ff <= d3_rem;
               d3_quo_ff <= {d3_quo_ff[SUM_W-D3_CHUNK-1:0], d3_digit};
               d3_cnt_ff <= d3_cnt_ff + 1'b1;
               if (d3_cnt_ff == D3_CNT_W'(D3_STEPS - 1)) begin
                  state_ff <= IN_NEXT;
               end
            end
            IN_NEXT: begin
               sq_ff <= sat_add(sq_ff, $signed(d3_quo_ff));
               if (idx_ff + 1'b1 < count_ff) begin
                  x0_ff    <= x1_ff;
                  y0_ff    <= y1_ff;
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= IN_C;
               end else begin
                  state_ff <= DONE;
               end
            end
            DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_value_ff  <= value_ff;
                  rsp_area_ff   <= area_ff;
                  rsp_sq_ff     <= sq_ff;
                  rsp_status_ff <= status_ff;
                  state_ff      <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_stall          = (state_ff != IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_value_out      = rsp_value_ff;
   assign rsp_area           = rsp_area_ff;
   assign rsp_area_of_square = rsp_sq_ff;
   assign rsp_status         = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count above table size");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ((count_ff == $past(count_ff) + 1'b1) || (count_ff == '0)))
      else $error("point count moved by more than one");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

   a_table_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (p_ff < CNT_W'(MAX_POINTS)))
      else $error("table write beyond last entry");

endmodule

/* rtl/core/plte_mul.sv */
// Registered signed multiplier shared by all product steps.
module plte_mul
   import plte_pkg::*;
(
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  a_in,
   input  logic signed [MUL_W-1:0]  b_in,
   output logic signed [PROD_W-1:0] prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= a_in * b_in;
   end

endmodule

/* rtl/core/plte_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned operands.
module plte_div
   import plte_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [DIV_W-1:0] quot
);

   logic [DVS_W-1:0]     rem_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DVS_W-1:0]     dvs_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DVS_W:0]       trial;
   logic                 fits;
   logic [DVS_W:0]       diff;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dvs_ff  <= divisor;
            cnt_ff  <= DIV_CNT_W'(DIV_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quo_ff;

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the piecewise-linear table engine.
`timescale 1ns / 100ps

module tb_top;
   import plte_pkg::*;

   localparam int  ITEM_TARGET = 950;
   localparam int  CYCLE_LIMIT = 10000000;
   localparam longint SUM_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint SUM_MIN  = 64'sh8000_0000_0000_0000;

   typedef struct {
      logic signed [VAL_W-1:0] value_out;
      logic signed [SUM_W-1:0] area;
      logic signed [SUM_W-1:0] area_sq;
      status_type              status;
   } outcome_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [1:0]              req_func = FUNC_CLEAR;
   logic [POS_W-1:0]        req_x = '0;
   logic signed [VAL_W-1:0] req_y = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [VAL_W-1:0] rsp_value_out;
   logic signed [SUM_W-1:0] rsp_area;
   logic signed [SUM_W-1:0] rsp_area_of_square;
   logic [1:0]              rsp_status;

   // table shadow kept by the predictor
   logic [POS_W-1:0]        shadow_pos [MAX_POINTS];
   logic signed [VAL_W-1:0] shadow_val [MAX_POINTS];
   int                      shadow_count = 0;

   outcome_type pending_q[$];
   int       mismatch_count = 0;
   int       sent_count = 0;
   int       burst_left = 0;
   int       cycle_count = 0;
   int       stall_phase = 0;

   piecewise_linear_table_engine_unit uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint sum_clamped(longint a, longint b);
      longint s;
      s = a + b;
      if (a > 0 && b > 0 && s < 0) return SUM_MAX;
      if (a < 0 && b < 0 && s >= 0) return SUM_MIN;
      return s;
   endfunction

   // applies one request to the shadow table and returns the expected result
   function automatic outcome_type apply_request(func_type f, logic [POS_W-1:0] x,
                                                 logic signed [VAL_W-1:0] y);
      outcome_type r;
      bit         dup;
      int         p;
      longint     d, y0, y1, num;
      logic [63:0]  q;
      logic [127:0] wide;
      r.value_out = '0;
      r.area      = '0;
      r.area_sq   = '0;
      r.status    = ST_OK;
      case (f)
         FUNC_INSERT: begin
            dup = 0;
            for (int i = 0; i < shadow_count; i++)
               if (shadow_pos[i] == x) dup = 1;
            if (dup) begin
               r.status = ST_DUP;
            end else if (shadow_count >= MAX_POINTS) begin
               r.status = ST_FULL;
            end else begin
               p = shadow_count;
               while (p > 0 && shadow_pos[p-1] > x) begin
                  shadow_pos[p] = shadow_pos[p-1];
                  shadow_val[p] = shadow_val[p-1];
                  p--;
               end
               shadow_pos[p] = x;
               shadow_val[p] = y;
               shadow_count++;
            end
         end
         FUNC_EVAL: begin
            r.status = ST_RANGE;
            for (int i = 0; i + 1 < shadow_count; i++) begin
               if (shadow_pos[i] <= x && x <= shadow_pos[i+1]) begin
                  d   = longint'(shadow_pos[i+1]) - longint'(shadow_pos[i]);
                  y0  = shadow_val[i];
                  y1  = shadow_val[i+1];
                  num = y0 * d + (longint'(x) - longint'(shadow_pos[i])) * (y1 - y0);
                  r.value_out = VAL_W'(num / d);
                  r.status    = ST_OK;
                  break;
               end
            end
         end
         FUNC_INTEG: begin
            for (int i = 0; i + 1 < shadow_count; i++) begin
               d  = longint'(shadow_pos[i+1]) - longint'(shadow_pos[i]);
               y0 = shadow_val[i];
               y1 = shadow_val[i+1];
               q  = 64'(y0 * y0) + 64'(y1 * y1) + 64'(y0 * y1);
               wide = 128'(d) * 128'(q);
               r.area    = sum_clamped(r.area, (d * (y0 + y1)) / 4);
               r.area_sq = sum_clamped(r.area_sq, longint'(wide / 128'd393216));
            end
         end
         default: shadow_count = 0;
      endcase
      return r;
   endfunction

   // called at a rising edge; returns after the handshake and any idle gap
   task automatic send_request(func_type f, logic [POS_W-1:0] x, logic signed [VAL_W-1:0] y);
      req_valid <= 1'b1;
      req_func  <= f;
      req_x     <= x;
      req_y     <= y;
      do @(posedge clock); while (req_stall);
      pending_q.push_back(apply_request(f, x, y));
      sent_count++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return VAL_W'($urandom_range(0, 131071)) - 32'sd65536;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_inside();
      if (shadow_count < 2) return POS_W'($urandom);
      return POS_W'($urandom_range(shadow_pos[0], shadow_pos[shadow_count-1]));
   endfunction

   task automatic test_empty_table();
      send_request(FUNC_EVAL, 16'd0, 32'sd0);
      send_request(FUNC_INTEG, 16'd0, 32'sd0);
      send_request(FUNC_INSERT, 16'd500, 32'sd65536);
      send_request(FUNC_EVAL, 16'd500, 32'sd0);     // single point is too few
      send_request(FUNC_INTEG, 16'd0, 32'sd0);
   endtask

   task automatic test_extremes();
      send_request(FUNC_CLEAR, 16'hFFFF, 32'sh7FFF_FFFF);
      send_request(FUNC_INSERT, 16'hFFFF, 32'sh7FFF_FFFF);
      send_request(FUNC_INSERT, 16'h0000, 32'sh8000_0000);
      send_request(FUNC_INSERT, 16'hFFFF, 32'sd1);  // duplicate
      send_request(FUNC_EVAL, 16'h0000, 32'sd0);
      send_request(FUNC_EVAL, 16'hFFFF, 32'sd0);
      send_request(FUNC_EVAL, 16'h8000, 32'sd0);
      send_request(FUNC_INTEG, 16'd0, 32'sd0);
      send_request(FUNC_INSERT, 16'h7FFF, 32'sh7FFF_FFFF);
      send_request(FUNC_INTEG, 16'd0, 32'sd0);
   endtask

   task automatic test_out_of_range();
      send_request(FUNC_CLEAR, 16'd0, 32'sd0);
      send_request(FUNC_INSERT, 16'd200, -32'sd70000);
      send_request(FUNC_INSERT, 16'd100, 32'sd300000);
      send_request(FUNC_EVAL, 16'd99, 32'sd0);
      send_request(FUNC_EVAL, 16'd201, 32'sd0);
      send_request(FUNC_EVAL, 16'd100, 32'sd0);
      send_request(FUNC_EVAL, 16'd200, 32'sd0);
      send_request(FUNC_EVAL, 16'd133, 32'sd0);
   endtask

   task automatic test_full_table();
      send_request(FUNC_CLEAR, 16'd0, 32'sd0);
      for (int i = 0; i < MAX_POINTS; i++)
         send_request(FUNC_INSERT, POS_W'(i * 1000 + 7), pick_value());
      send_request(FUNC_INSERT, 16'd3, 32'sd5);
      send_request(FUNC_INSERT, 16'd7, 32'sd5);      // duplicate wins over full
      send_request(FUNC_EVAL, pick_inside(), 32'sd0);
      send_request(FUNC_INTEG, 16'd0, 32'sd0);
   endtask

   task automatic test_random_sequences();
      int k;
      while (sent_count < ITEM_TARGET) begin
         send_request(FUNC_CLEAR, POS_W'($urandom), VAL_W'($urandom));
         k = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 70) : $urandom_range(0, 8);
         for (int i = 0; i < k; i++) begin
            if (shadow_count > 0 && $urandom_range(0, 9) == 0)
               send_request(FUNC_INSERT, shadow_pos[$urandom_range(0, shadow_count-1)],
                            pick_value());
            else
               send_request(FUNC_INSERT, POS_W'($urandom), pick_value());
         end
         repeat ($urandom_range(1, 7)) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: send_request(FUNC_EVAL, pick_inside(), VAL_W'($urandom));
               4:          send_request(FUNC_EVAL, POS_W'($urandom), VAL_W'($urandom));
               5, 6:       send_request(FUNC_INTEG, POS_W'($urandom), VAL_W'($urandom));
               7:          send_request(FUNC_INSERT, POS_W'($urandom), pick_value());
               default:    send_request(func_type'($urandom_range(0, 2)), POS_W'($urandom),
                                        VAL_W'($urandom));
            endcase
         end
         if ($urandom_range(0, 40) == 0) wait_drained();
      end
   endtask

   // receiver stall pattern cycles through several modes
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         case (stall_phase[9:8])
            2'd0: rsp_stall <= 1'b0;
            2'd1: rsp_stall <= $urandom_range(0, 1);
            2'd2: rsp_stall <= (stall_phase[2:0] < 3'd5);
            default: rsp_stall <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: value %0d status %0d", rsp_value_out, rsp_status);
         end else begin
            e = pending_q.pop_front();
            if (rsp_value_out !== e.value_out || rsp_area !== e.area ||
                rsp_area_of_square !== e.area_sq || rsp_status !== e.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: value %0d/%0d area %0d/%0d sq %0d/%0d status %0d/%0d",
                           e.value_out, rsp_value_out, e.area, rsp_area,
                           e.area_sq, rsp_area_of_square, e.status, rsp_status);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_extremes();
      test_out_of_range();
      wait_drained();
      test_full_table();
      test_random_sequences();
      wait_drained();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && pending_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/plte_pkg.sv
rtl/core/plte_mul.sv
rtl/core/plte_div.sv
rtl/core/piecewise_linear_table_engine_unit.sv
tb/sv/tb_top.sv
